### sv/tfp_pkg.sv
// tfp_pkg: shared types and constants for the telemetry frame parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tfp_pkg;

    // crc-8 generator polynomial (x^8 + x^2 + x + 1), start value zero
    localparam logic [7:0] CRC_POLY        = 8'h07;
    // header bytes counted in the length field
    localparam int         HEADER_LEN      = 8;
    // default largest payload in bytes
    localparam int         MAX_PAYLOAD_DEF = 255;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_CRC_GOOD = 2'd1;
    localparam logic [1:0] KIND_CRC_BAD  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SYNC_VALUE   = 2'd0;
    localparam logic [1:0] REG_TYPE_MASK    = 2'd1;
    localparam logic [1:0] REG_TYPE_VERSION = 2'd2;

    // configuration reset values
    localparam logic [7:0] SYNC_VALUE_RST   = 8'd60;
    localparam logic [7:0] TYPE_MASK_RST    = 8'd248;
    localparam logic [7:0] TYPE_VERSION_RST = 8'd32;

    // configuration seen by the parser
    typedef struct packed {
        logic [7:0] sync_value;
        logic [7:0] type_mask;
        logic [7:0] type_version;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  byte_index;
        logic [7:0]  message_type;
        logic [8:0]  frame_length;
        logic [31:0] object_id;
    } t_result;

endpackage

### sv/tfp_crc8.sv
// tfp_crc8: one-byte update of the crc-8 (poly 0x07, msb first)
// depends on tfp_pkg for the polynomial
`timescale 1ns / 1ps

module tfp_crc8
    import tfp_pkg::*;
(
    input  logic [7:0] i_crc,
    input  logic [7:0] i_data,
    output logic [7:0] o_crc
);

    // eight shift-and-xor steps on the byte
    always_comb begin
        logic [7:0] v_r;
        v_r = i_crc ^ i_data;
        for (int k = 0; k < 8; k++) begin
            if (v_r[7]) begin
                v_r = {v_r[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_r = {v_r[6:0], 1'b0};
            end
        end
        o_crc = v_r;
    end

endmodule

### sv/tfp_cfg_regs.sv
// tfp_cfg_regs: apb-style register file for sync value, type mask and version
// depends on tfp_pkg for register indexes, reset values and t_cfg
`timescale 1ns / 1ps

module tfp_cfg_regs
    import tfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [7:0] r_sync_value;
    logic [7:0] r_type_mask;
    logic [7:0] r_type_version;
    logic       w_wr;
    logic [1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[3:2];

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value   <= SYNC_VALUE_RST;
            r_type_mask    <= TYPE_MASK_RST;
            r_type_version <= TYPE_VERSION_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SYNC_VALUE:   r_sync_value   <= pwdata[7:0];
                REG_TYPE_MASK:    r_type_mask    <= pwdata[7:0];
                REG_TYPE_VERSION: r_type_version <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux, unmapped addresses read zero
    always_comb begin
        unique case (w_idx)
            REG_SYNC_VALUE:   prdata = {24'd0, r_sync_value};
            REG_TYPE_MASK:    prdata = {24'd0, r_type_mask};
            REG_TYPE_VERSION: prdata = {24'd0, r_type_version};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg = '{sync_value: r_sync_value, type_mask: r_type_mask,
                     type_version: r_type_version};

endmodule

### sv/tfp_parser.sv
// tfp_parser: per-byte frame state machine, header capture and crc check
// depends on tfp_pkg and tfp_crc8
`timescale 1ns / 1ps

module tfp_parser
    import tfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output logic       o_emit,
    output t_result    o_result
);

    // parse phases
    localparam logic [2:0] PH_SYNC = 3'd0;
    localparam logic [2:0] PH_TYPE = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_ID   = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CRC  = 3'd5;

    localparam logic [15:0] LEN_MIN = 16'(HEADER_LEN);
    localparam logic [15:0] LEN_MAX = 16'(MAX_PAYLOAD + HEADER_LEN);
    localparam logic [8:0]  HDR_9   = 9'(HEADER_LEN);

    logic [2:0]  r_phase,  n_phase;
    logic [7:0]  r_crc,    n_crc;
    logic [7:0]  r_cnt,    n_cnt;
    logic [7:0]  r_type,   n_type;
    logic [8:0]  r_len,    n_len;
    logic [31:0] r_id,     n_id;

    logic [7:0]  w_crc_in;
    logic [7:0]  w_crc_next;
    logic [15:0] w_len_full;
    logic [8:0]  w_cnt_inc;

    // crc restarts from zero on the sync byte
    assign w_crc_in   = (r_phase == PH_TYPE || r_phase == PH_LEN || r_phase == PH_ID ||
                         r_phase == PH_DATA) ? r_crc : 8'd0;
    assign w_len_full = {i_byte, r_len[7:0]};
    assign w_cnt_inc  = {1'b0, r_cnt} + 9'd1;

    tfp_crc8 u_crc (
        .i_crc  (w_crc_in),
        .i_data (i_byte),
        .o_crc  (w_crc_next)
    );

    // next state and result for the byte at hand
    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_cnt    = r_cnt;
        n_type   = r_type;
        n_len    = r_len;
        n_id     = r_id;
        o_emit   = 1'b0;
        o_result = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, byte_index: 8'd0,
                     message_type: r_type, frame_length: r_len, object_id: r_id};
        unique case (r_phase)
            PH_TYPE: begin
                n_crc = w_crc_next;
                if ((i_byte & i_cfg.type_mask) == i_cfg.type_version) begin
                    n_type  = i_byte;
                    n_cnt   = 8'd0;
                    n_phase = PH_LEN;
                end else begin
                    n_phase = PH_SYNC;
                end
            end
            PH_LEN: begin
                n_crc = w_crc_next;
                if (r_cnt == 8'd0) begin
                    n_len = {1'b0, i_byte};
                    n_cnt = 8'd1;
                end else if (w_len_full < LEN_MIN || w_len_full > LEN_MAX) begin
                    // bad length, frame dropped
                    n_phase = PH_SYNC;
                end else begin
                    n_len   = w_len_full[8:0];
                    n_cnt   = 8'd0;
                    n_phase = PH_ID;
                end
            end
            PH_ID: begin
                n_crc = w_crc_next;
                // little-endian assembly of the object id
                case (r_cnt[1:0])
                    2'd0:    n_id = {24'd0, i_byte};
                    2'd1:    n_id[15:8]  = i_byte;
                    2'd2:    n_id[23:16] = i_byte;
                    default: n_id[31:24] = i_byte;
                endcase
                if (w_cnt_inc >= 9'd4) begin
                    n_cnt   = 8'd0;
                    n_phase = (r_len == HDR_9) ? PH_CRC : PH_DATA;
                end else begin
                    n_cnt = w_cnt_inc[7:0];
                end
            end
            PH_DATA: begin
                n_crc  = w_crc_next;
                o_emit = 1'b1;
                o_result.payload_byte = i_byte;
                o_result.byte_index   = r_cnt;
                if (w_cnt_inc >= r_len - HDR_9) begin
                    n_cnt   = 8'd0;
                    n_phase = PH_CRC;
                end else begin
                    n_cnt = w_cnt_inc[7:0];
                end
            end
            PH_CRC: begin
                o_emit = 1'b1;
                o_result.kind = (i_byte == r_crc) ? KIND_CRC_GOOD : KIND_CRC_BAD;
                n_phase = PH_SYNC;
            end
            default: begin
                // hunting for sync
                n_phase = PH_SYNC;
                if (i_byte == i_cfg.sync_value) begin
                    n_crc   = w_crc_next;
                    n_phase = PH_TYPE;
                end
            end
        endcase
    end

    // state registers advance once per processed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_crc   <= 8'd0;
            r_cnt   <= 8'd0;
            r_type  <= 8'd0;
            r_len   <= 9'd0;
            r_id    <= 32'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_crc   <= n_crc;
            r_cnt   <= n_cnt;
            r_type  <= n_type;
            r_len   <= n_len;
            r_id    <= n_id;
        end
    end

endmodule

### sv/telemetry_frame_parser_core.sv
// telemetry_frame_parser_core: top level of the sync-framed telemetry parser
// depends on tfp_pkg, tfp_cfg_regs, tfp_parser and tfp_crc8
`timescale 1ns / 1ps

// Usage
// - input stream s_*: one received byte per transfer in s_tdata[7:0].
// - output stream m_*: one result per payload byte (kind payload) and one per
//   frame end (kind crc good or crc bad); consumers drop the payload of a bad
//   frame. Frames with a bad type or length vanish without any result.
// - apb port: sync value at 0x0, type mask at 0x4, type version at 0x8;
//   write only while the stream is idle.
// Timing
// - one byte per cycle sustained unless a result stalls on m_tready; the frame
//   state machine with its byte-wide crc update forms the single stage between
//   the input register and the result register.
// - a byte in the input register is processed when the parser steps, and its
//   result goes into the result register that drives m_tvalid/m_tdata.
// Reset and stall
// - synchronous active-low reset clears the registers to their defaults, the
//   parser to sync hunting, and both the input and result registers to empty.
// - while the result register waits on m_tready, the byte in the input
//   register holds and s_tready drops until the result is taken.

module telemetry_frame_parser_core
    import tfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [7:0] payload_byte, [15:8] byte_index,
                                   // [23:16] message_type, [32:24] frame_length,
                                   // [64:33] object_id, [71:65] zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    logic       w_step;
    logic       w_emit;
    t_result    w_result;
    t_cfg       w_cfg;

    tfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // the held byte moves on whenever the result slot is free or draining
    assign w_step   = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
        end
    end

    tfp_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_in_byte),
        .i_cfg    (w_cfg),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_step && w_emit) begin
            r_out <= w_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_out.kind;
    assign m_tdata  = {7'd0, r_out.object_id, r_out.frame_length, r_out.message_type,
                       r_out.byte_index, r_out.payload_byte};

    // results only ever carry a length that passed the range check
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[32:24] >= 9'(HEADER_LEN)) &&
                     ({23'd0, m_tdata[32:24]} <= 32'(MAX_PAYLOAD + HEADER_LEN)))
        else $error("result frame length out of range");

    // a payload byte lies inside the payload announced by the length
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser == KIND_PAYLOAD) |->
            ({1'b0, m_tdata[15:8]} < m_tdata[32:24] - 9'(HEADER_LEN)))
        else $error("payload index beyond frame length");

    // no undefined kind code reaches the output
    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == KIND_PAYLOAD || m_tuser == KIND_CRC_GOOD ||
                      m_tuser == KIND_CRC_BAD))
        else $error("undefined result kind");

    // a stalled result must not be overwritten by a new byte
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |-> !w_step)
        else $error("parser stepped while result stalled");

endmodule
